// ----- src/multi_cpu_ready_queue_scheduler_defines.svh -----
// Assertion macros used by the scheduler controller.
// No dependencies.
`ifndef MULTI_CPU_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTI_CPU_READY_QUEUE_SCHEDULER_DEFINES_SVH

`define MCRQ_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define MCRQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- src/mcrq_pkg.sv -----
// Shared types and constants of the ready-queue scheduler.
// No dependencies.
package mcrq_pkg;
   localparam int QueueDepth = 32;
   localparam int MaxCpus    = 16;
   localparam int QaW        = $clog2(QueueDepth);
   localparam int QcW        = $clog2(QueueDepth + 1);
   localparam int CpuW       = 4;

   localparam logic [1:0] FUNC_DISPATCH = 2'd0;
   localparam logic [1:0] FUNC_PREEMPT  = 2'd1;
   localparam logic [1:0] FUNC_RELEASE  = 2'd2;
   localparam logic [1:0] FUNC_WAKE     = 2'd3;

   localparam logic [1:0] MODE_RR   = 2'd1;
   localparam logic [1:0] MODE_PRIO = 2'd2;

   localparam logic [2:0] KIND_DISPATCHED = 3'd0;
   localparam logic [2:0] KIND_IDLE       = 3'd1;
   localparam logic [2:0] KIND_PREEMPT    = 3'd2;
   localparam logic [2:0] KIND_NOTHING    = 3'd3;
   localparam logic [2:0] KIND_FULL       = 3'd4;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_SLICE  = 2'd1;
   localparam logic [1:0] REG_ACTIVE = 2'd2;

   typedef struct packed {
      logic           load;      // latch request, decode
      logic           append;    // write tail from append source
      logic           src_run;   // append source is running entry of cpu
      logic           scan_clr;  // start priority scan
      logic           scan_step; // examine rd_data at scan index
      logic [QaW-1:0] rd_addr;
      logic           sh_wr;     // write shifted entry
      logic [QaW-1:0] sh_addr;
      logic           pop;       // decrement count
      logic           take;      // capture rd_data as dispatched entry
      logic           run_set;   // set running entry of cpu from taken
      logic           run_clr;
      logic           victim_clr;
      logic           victim_step;
      logic [CpuW-1:0] vidx;
   } ctl_type;

   typedef struct packed {
      logic [1:0]     func;
      logic [CpuW-1:0] cpu;
      logic [QcW-1:0] count;
      logic           run_valid;
      logic [QaW-1:0] pick;
      logic           victim_found;
      logic [CpuW-1:0] victim;
      logic           any_idle;
   } sts_type;
endpackage

// ----- src/multi_cpu_ready_queue_scheduler.sv -----
// A refused or ignored request goes from decode straight to the response; a wake appends,
// after a scan of the active CPUs in priority mode; a dispatch on an empty queue answers idle;
// else the pick is fetched and later entries are shifted, after a scan in priority mode.
// One request in flight; the next is accepted in the cycle after the response handshake.
// Synchronous active-high reset empties the queue, idles every CPU and loads mode 0,
// slice 0 and one active CPU. Depends on mcrq_pkg, mcrq_ctrl and mcrq_datapath.
module multi_cpu_ready_queue_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cpu[3:0], proc_id[11:4], proc_priority[19:12], zero
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // target_cpu[3:0], run_id[11:4], slice_out[27:12], zero
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [1:0]  mode_ff;
   logic [15:0] slice_ff;
   logic [4:0]  active_ff;
   logic        req_fire, rsp_fire, busy, rsp_valid;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_data;
   logic [7:0]  taken_id;
   mcrq_pkg::ctl_type ctl;
   mcrq_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = rsp_data;
   assign rsp_tuser  = rsp_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         slice_ff  <= '0;
         active_ff <= 5'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            mcrq_pkg::REG_MODE:   mode_ff   <= csr_pwdata[1:0];
            mcrq_pkg::REG_SLICE:  slice_ff  <= csr_pwdata[15:0];
            mcrq_pkg::REG_ACTIVE: active_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         mcrq_pkg::REG_MODE:   csr_prdata = {30'd0, mode_ff};
         mcrq_pkg::REG_SLICE:  csr_prdata = {16'd0, slice_ff};
         mcrq_pkg::REG_ACTIVE: csr_prdata = {27'd0, active_ff};
         default: csr_prdata = '0;
      endcase
   end

   mcrq_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .func          (req_tuser),
      .cpu           (req_tdata[3:0]),
      .proc_id       (req_tdata[11:4]),
      .proc_priority (req_tdata[19:12]),
      .mode          (mode_ff),
      .sts           (sts),
      .taken_id      (taken_id)
   );

   mcrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .mode      (mode_ff),
      .slice_len (slice_ff),
      .active    (active_ff),
      .sts       (sts),
      .taken_id  (taken_id),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_kind  (rsp_kind),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- src/mcrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcrq_ram #(
   parameter int Width = 16,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- src/mcrq_datapath.sv -----
// Datapath: queue RAM, per-CPU running table, scan and victim registers.
// Depends on mcrq_pkg and mcrq_ram.
module mcrq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mcrq_pkg::ctl_type       ctl,
   input  logic [1:0]              func,
   input  logic [3:0]              cpu,
   input  logic [7:0]              proc_id,
   input  logic [7:0]              proc_priority,
   input  logic [1:0]              mode,
   output mcrq_pkg::sts_type       sts,
   output logic [7:0]              taken_id
);
   localparam int QaW = mcrq_pkg::QaW;
   localparam int QcW = mcrq_pkg::QcW;

   logic [1:0]     func_ff;
   logic [3:0]     cpu_ff;
   logic [7:0]     pid_ff, pprio_ff;
   logic [QcW-1:0] count_ff;
   logic [7:0]     run_id_ff [mcrq_pkg::MaxCpus];
   logic [7:0]     run_prio_ff [mcrq_pkg::MaxCpus];
   logic [mcrq_pkg::MaxCpus-1:0] run_valid_ff;
   logic [QaW-1:0] pick_ff, scan_ff;
   logic [7:0]     best_ff;
   logic           victim_found_ff;
   logic [3:0]     victim_ff;
   logic [7:0]     taken_id_ff, taken_prio_ff;

   logic           wr_en;
   logic [QaW-1:0] wr_addr;
   logic [15:0]    wr_data, rd_data;

   always_comb begin
      wr_en   = ctl.append | ctl.sh_wr;
      wr_addr = ctl.append ? count_ff[QaW-1:0] : ctl.sh_addr;
      if (ctl.sh_wr) begin
         wr_data = rd_data;
      end else if (ctl.src_run) begin
         wr_data = {run_prio_ff[cpu_ff], run_id_ff[cpu_ff]};
      end else begin
         wr_data = {pprio_ff, pid_ff};
      end
   end

   mcrq_ram #(.Width(16), .Depth(mcrq_pkg::QueueDepth)) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ctl.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         func_ff  <= func;
         cpu_ff   <= cpu;
         pid_ff   <= proc_id;
         pprio_ff <= proc_priority;
      end
      if (ctl.scan_clr) begin
         pick_ff <= '0;
         scan_ff <= '0;
         best_ff <= '0;
      end else if (ctl.scan_step) begin
         if (scan_ff == '0 || rd_data[15:8] > best_ff) begin
            pick_ff <= scan_ff;
            best_ff <= rd_data[15:8];
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (ctl.take) begin
         taken_id_ff   <= rd_data[7:0];
         taken_prio_ff <= rd_data[15:8];
      end
      if (ctl.run_set) begin
         run_id_ff[cpu_ff]   <= taken_id_ff;
         run_prio_ff[cpu_ff] <= taken_prio_ff;
      end
      if (ctl.victim_clr) begin
         victim_found_ff <= 1'b0;
         victim_ff       <= '0;
      end else if (ctl.victim_step && !victim_found_ff
                   && run_prio_ff[ctl.vidx] < pprio_ff) begin
         victim_found_ff <= 1'b1;
         victim_ff       <= ctl.vidx;
      end
      if (reset) begin
         count_ff     <= '0;
         run_valid_ff <= '0;
      end else begin
         if (ctl.append) begin
            count_ff <= count_ff + 1'b1;
         end else if (ctl.pop) begin
            count_ff <= count_ff - 1'b1;
         end
         if (ctl.run_set) begin
            run_valid_ff[cpu_ff] <= 1'b1;
         end else if (ctl.run_clr) begin
            run_valid_ff[cpu_ff] <= 1'b0;
         end
      end
   end

   assign sts.func         = func_ff;
   assign sts.cpu          = cpu_ff;
   assign sts.count        = count_ff;
   assign sts.run_valid    = run_valid_ff[cpu_ff];
   assign sts.pick         = (mode == mcrq_pkg::MODE_PRIO) ? pick_ff : '0;
   assign sts.victim_found = victim_found_ff;
   assign sts.victim       = victim_ff;
   assign sts.any_idle     = !run_valid_ff[ctl.vidx];
   assign taken_id         = taken_id_ff;
endmodule

// ----- src/mcrq_ctrl.sv -----
// Controller state machine sequencing scan, compaction and result delivery.
// Depends on mcrq_pkg and the assertion macro header.
`include "multi_cpu_ready_queue_scheduler_defines.svh"
module mcrq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                rsp_fire,
   input  logic [1:0]          mode,
   input  logic [15:0]         slice_len,
   input  logic [4:0]          active,
   input  mcrq_pkg::sts_type   sts,
   input  logic [7:0]          taken_id,
   output mcrq_pkg::ctl_type   ctl,
   output logic                busy,
   output logic                rsp_valid,
   output logic [2:0]          rsp_kind,
   output logic [31:0]         rsp_data
);
   localparam int QaW = mcrq_pkg::QaW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_WAKE_SCAN, S_APPEND, S_PSCAN, S_PSCAN_END,
      S_FETCH, S_TAKE, S_SHIFT, S_POP, S_OUT
   } state_type;

   state_type      state_ff;
   logic [QaW:0]   idx_ff;
   logic [4:0]     n_cpu;
   logic [2:0]     kind_ff;
   logic [3:0]     tgt_ff;
   logic [7:0]     id_ff;
   logic [15:0]    sl_ff;
   logic           idle_seen_ff;
   logic [QaW-1:0] last_idx;

   assign n_cpu    = (active > 5'(mcrq_pkg::MaxCpus)) ? 5'(mcrq_pkg::MaxCpus) : active;
   assign last_idx = QaW'(sts.count - 1'b1);

   always_comb begin
      ctl = '0;
      ctl.vidx = idx_ff[3:0];
      unique case (state_ff)
         S_IDLE: ctl.load = req_fire;
         S_DECODE: begin
            ctl.scan_clr   = 1'b1;
            ctl.victim_clr = 1'b1;
            ctl.rd_addr    = '0;
         end
         S_WAKE_SCAN: ctl.victim_step = idle_seen_ff ? 1'b0 : 1'b1;
         S_APPEND: begin
            ctl.append  = (sts.func == mcrq_pkg::FUNC_WAKE) ||
                          (sts.func == mcrq_pkg::FUNC_PREEMPT && sts.run_valid);
            ctl.src_run = (sts.func == mcrq_pkg::FUNC_PREEMPT);
            ctl.run_clr = (sts.func == mcrq_pkg::FUNC_PREEMPT);
         end
         S_PSCAN_END: ctl.run_clr = (sts.count == '0);
         S_PSCAN: begin
            ctl.scan_step = 1'b1;
            ctl.rd_addr   = QaW'(idx_ff + 1'b1);
         end
         S_FETCH: ctl.rd_addr = sts.pick;
         S_TAKE: begin
            ctl.take    = 1'b1;
            ctl.rd_addr = QaW'(idx_ff + 1'b1);
         end
         S_SHIFT: begin
            ctl.sh_wr   = 1'b1;
            ctl.sh_addr = idx_ff[QaW-1:0];
            ctl.rd_addr = QaW'(idx_ff + 2'd2);
         end
         S_POP: begin
            ctl.pop     = 1'b1;
            ctl.run_set = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         idle_seen_ff <= 1'b0;
         kind_ff      <= mcrq_pkg::KIND_NOTHING;
         tgt_ff       <= '0;
         id_ff        <= '0;
         sl_ff        <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_fire) state_ff <= S_DECODE;
            S_DECODE: begin
               idx_ff       <= '0;
               idle_seen_ff <= 1'b0;
               id_ff        <= '0;
               sl_ff        <= '0;
               if (sts.func == mcrq_pkg::FUNC_WAKE) begin
                  tgt_ff <= '0;
                  if (sts.count >= (QaW+1)'(mcrq_pkg::QueueDepth)) begin
                     kind_ff  <= mcrq_pkg::KIND_FULL;
                     state_ff <= S_OUT;
                  end else if (mode == mcrq_pkg::MODE_PRIO && n_cpu != '0) begin
                     state_ff <= S_WAKE_SCAN;
                  end else begin
                     state_ff <= S_APPEND;
                  end
               end else begin
                  tgt_ff <= sts.cpu;
                  if ({1'b0, sts.cpu} >= n_cpu) begin
                     kind_ff  <= mcrq_pkg::KIND_NOTHING;
                     state_ff <= S_OUT;
                  end else if (sts.func == mcrq_pkg::FUNC_PREEMPT && sts.run_valid) begin
                     if (sts.count >= (QaW+1)'(mcrq_pkg::QueueDepth)) begin
                        kind_ff  <= mcrq_pkg::KIND_FULL;
                        state_ff <= S_OUT;
                     end else begin
                        state_ff <= S_APPEND;
                     end
                  end else begin
                     state_ff <= S_APPEND;
                  end
               end
            end
            S_WAKE_SCAN: begin
               if (sts.any_idle) idle_seen_ff <= 1'b1;
               if (5'(idx_ff) + 5'd1 >= n_cpu) begin
                  idx_ff   <= '0;
                  state_ff <= S_APPEND;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_APPEND: begin
               if (sts.func == mcrq_pkg::FUNC_WAKE) begin
                  if (mode == mcrq_pkg::MODE_PRIO && n_cpu != '0 && !idle_seen_ff
                      && sts.victim_found) begin
                     kind_ff <= mcrq_pkg::KIND_PREEMPT;
                     tgt_ff  <= sts.victim;
                  end else begin
                     kind_ff <= mcrq_pkg::KIND_NOTHING;
                  end
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_PSCAN_END;
                  idx_ff   <= '0;
               end
            end
            S_PSCAN_END: begin
               // Queue count now includes any appended preempted entry.
               if (sts.count == '0) begin
                  kind_ff  <= mcrq_pkg::KIND_IDLE;
                  state_ff <= S_OUT;
               end else if (mode == mcrq_pkg::MODE_PRIO) begin
                  idx_ff   <= '0;
                  state_ff <= S_PSCAN;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_PSCAN: begin
               if ((idx_ff + 1'b1) >= sts.count) begin
                  state_ff <= S_FETCH;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FETCH: begin
               idx_ff   <= {1'b0, sts.pick};
               state_ff <= S_TAKE;
            end
            S_TAKE: state_ff <= (idx_ff[QaW-1:0] == last_idx) ? S_POP : S_SHIFT;
            S_SHIFT: begin
               if (idx_ff[QaW-1:0] + 1'b1 == last_idx) begin
                  state_ff <= S_POP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_POP: begin
               kind_ff  <= mcrq_pkg::KIND_DISPATCHED;
               id_ff    <= taken_id;
               sl_ff    <= (mode == mcrq_pkg::MODE_RR) ? slice_len : 16'd0;
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_fire) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // In S_PSCAN the scan reads entry idx; the read for it was issued in the previous cycle.
   // An empty queue at S_PSCAN_END leaves the CPU idle.
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_kind  = kind_ff;
   assign rsp_data  = {4'd0, sl_ff, id_ff, tgt_ff};

   `MCRQ_ASSERT_IMPL(a_out_kind, clock, reset, rsp_valid,
      kind_ff == mcrq_pkg::KIND_DISPATCHED || kind_ff == mcrq_pkg::KIND_IDLE ||
      kind_ff == mcrq_pkg::KIND_PREEMPT || kind_ff == mcrq_pkg::KIND_NOTHING ||
      kind_ff == mcrq_pkg::KIND_FULL)
   `MCRQ_ASSERT_IMPL(a_id_only_dispatch, clock, reset,
      rsp_valid && kind_ff != mcrq_pkg::KIND_DISPATCHED, id_ff == 8'd0)
   `MCRQ_ASSERT_NEXT(a_pop_to_out, clock, reset, state_ff == S_POP, rsp_valid)
endmodule
